>>> hw/rtl/ray_box_slab_intersect_macros.svh
// Assertion macros for the ray box slab intersection block.
// Depends on a clk and an active-low rst_n in the module that uses them.
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`ifndef SYNTHESIS
`define RBSI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbsi assertion failed");
`define RBSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("rbsi assertion failed");
`else
`define RBSI_ASSERT_IMPL(label, ante, cons)
`define RBSI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/rbsi_pkg.sv
// Package for the ray box slab intersection block: widths, constants and word types.
// Depends on nothing; used by the top level ray_box_slab_intersect.
`default_nettype none
package rbsi_pkg;

    localparam int COORD_W       = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
        coord_t dir_x;
        coord_t dir_y;
        coord_t dir_z;
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_min_z;
        coord_t box_max_x;
        coord_t box_max_y;
        coord_t box_max_z;
    } in_t;

    typedef struct packed {
        logic   hit;
        coord_t hit_t;
        coord_t hit_x;
        coord_t hit_y;
        coord_t hit_z;
    } res_t;

    typedef struct packed {
        logic   par_miss;
        logic [2:0] par;
        coord_t org_x;
        coord_t org_y;
        coord_t org_z;
        coord_t dir_x;
        coord_t dir_y;
        coord_t dir_z;
    } side_t;

endpackage
`default_nettype wire

>>> hw/rtl/rbsi_div_pipe.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Depends on nothing but its parameters; used by the top level once per slab plane.
`default_nettype none
module rbsi_div_pipe #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 32
) (
    input  wire logic                    clk,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic signed [DEN_W-1:0] den,
    output logic signed [NUM_W:0]        quo
);

    logic [DEN_W-1:0] rem_reg [0:NUM_W];
    logic [NUM_W-1:0] nq_reg  [0:NUM_W];
    logic [DEN_W-1:0] d_reg   [0:NUM_W];
    logic             neg_reg [0:NUM_W];
    logic signed [NUM_W:0] quo_reg;

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        nq_reg[0]  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        d_reg[0]   <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   sub;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[s], nq_reg[s][NUM_W-1]};
            sub      = trial - {1'b0, d_reg[s]};
            ge       = trial >= {1'b0, d_reg[s]};
            rem_next = ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= rem_next;
            nq_reg[s+1]  <= {nq_reg[s][NUM_W-2:0], ge};
            d_reg[s+1]   <= d_reg[s];
            neg_reg[s+1] <= neg_reg[s];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= neg_reg[NUM_W] ? -$signed({1'b0, nq_reg[NUM_W]})
                                  : $signed({1'b0, nq_reg[NUM_W]});
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

>>> hw/rtl/rbsi_delay.sv
// Delay line that carries a word and its valid bit alongside the divider pipeline.
// Depends on nothing but its parameters.
`default_nettype none
module rbsi_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    output logic [W-1:0]      out_data
);

    logic [DEPTH-1:0] v_reg;
    logic [W-1:0]     d_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg[0] <= in_data;
        for (int i = 1; i < DEPTH; i++)
        begin
            d_reg[i] <= d_reg[i-1];
        end
    end

    assign out_valid = v_reg[DEPTH-1];
    assign out_data  = d_reg[DEPTH-1];

endmodule
`default_nettype wire

>>> hw/rtl/ray_box_slab_intersect.sv
// Top level of the ray box slab intersection block: input stage, slab folding and hit point.
// Depends on rbsi_pkg, rbsi_div_pipe, rbsi_delay and the assertion macro header.
//
// Channel   Direction  Handshake            Word
// item      in         start and not busy   in_t: ray origin, direction, box corners
// result    out        done, one cycle      res_t: hit flag, t and hit point
//
// One ray is taken in every cycle; busy is always low.
// Coordinates are Q16.16 by default; the six pipelined dividers give one quotient bit per stage.
// Reset clears only the valid bits; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
`include "ray_box_slab_intersect_macros.svh"
module ray_box_slab_intersect
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire in_t  item,
    output logic      done,
    output res_t      result
);

    localparam int NUM_W   = COORD_W + 1 + FRAC_BITS;
    localparam int QW      = NUM_W + 1;
    localparam int DIV_LAT = NUM_W + 2;
    localparam int PW      = 2 * COORD_W;

    typedef struct packed {
        logic                 bnd;
        logic signed [QW-1:0] lo;
        logic signed [QW-1:0] hi;
    } rng_t;

    function automatic rng_t fold(input rng_t a, input rng_t b);
        rng_t r;
        r = a;
        if (!a.bnd)
        begin
            r = b;
        end
        else if (b.bnd)
        begin
            r.lo = (b.lo > a.lo) ? b.lo : a.lo;
            r.hi = (b.hi < a.hi) ? b.hi : a.hi;
        end
        return r;
    endfunction

    function automatic coord_t sat_q(input logic signed [QW-1:0] v);
        coord_t r;
        if ((&v[QW-1:COORD_W-1]) || !(|v[QW-1:COORD_W-1]))
        begin
            r = v[COORD_W-1:0];
        end
        else
        begin
            r = v[QW-1] ? COORD_MIN : COORD_MAX;
        end
        return r;
    endfunction

    function automatic coord_t sat_p(input logic signed [PW:0] v);
        coord_t r;
        if ((&v[PW:COORD_W-1]) || !(|v[PW:COORD_W-1]))
        begin
            r = v[COORD_W-1:0];
        end
        else
        begin
            r = v[PW] ? COORD_MIN : COORD_MAX;
        end
        return r;
    endfunction

    assign busy = 1'b0;

    // Stage A: input register.
    logic va_reg;
    in_t  in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= item;
        end
    end

    // Stage B: plane offsets scaled to the fixed-point grid, parallel slab checks.
    coord_t org [0:2];
    coord_t dir [0:2];
    coord_t bmin [0:2];
    coord_t bmax [0:2];

    assign org[0]  = in_reg.origin_x;
    assign org[1]  = in_reg.origin_y;
    assign org[2]  = in_reg.origin_z;
    assign dir[0]  = in_reg.dir_x;
    assign dir[1]  = in_reg.dir_y;
    assign dir[2]  = in_reg.dir_z;
    assign bmin[0] = in_reg.box_min_x;
    assign bmin[1] = in_reg.box_min_y;
    assign bmin[2] = in_reg.box_min_z;
    assign bmax[0] = in_reg.box_max_x;
    assign bmax[1] = in_reg.box_max_y;
    assign bmax[2] = in_reg.box_max_z;

    logic signed [NUM_W-1:0] num_next [0:5];
    coord_t                  den_next [0:2];
    side_t                   side_next;
    logic                    vb_reg;
    logic signed [NUM_W-1:0] num_reg [0:5];
    coord_t                  den_reg [0:2];
    side_t                   side_b_reg;

    always_comb
    begin
        side_next          = '0;
        side_next.org_x    = org[0];
        side_next.org_y    = org[1];
        side_next.org_z    = org[2];
        side_next.dir_x    = dir[0];
        side_next.dir_y    = dir[1];
        side_next.dir_z    = dir[2];
        for (int a = 0; a < 3; a++)
        begin
            num_next[a]   = {($signed({bmin[a][COORD_W-1], bmin[a]})
                             - $signed({org[a][COORD_W-1], org[a]})), {FRAC_BITS{1'b0}}};
            num_next[a+3] = {($signed({bmax[a][COORD_W-1], bmax[a]})
                             - $signed({org[a][COORD_W-1], org[a]})), {FRAC_BITS{1'b0}}};
            side_next.par[a] = (dir[a] == '0);
            den_next[a]   = side_next.par[a] ? coord_t'(1) : dir[a];
            if (side_next.par[a] && (org[a] < bmin[a] || org[a] > bmax[a]))
            begin
                side_next.par_miss = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        den_reg    <= den_next;
        side_b_reg <= side_next;
    end

    // Divider pipelines, one per slab plane, with the side word delayed alongside.
    logic signed [QW-1:0] quo [0:5];

    for (genvar p = 0; p < 6; p++) begin : g_div
        rbsi_div_pipe #(
            .NUM_W (NUM_W),
            .DEN_W (COORD_W)
        ) u_div (
            .clk (clk),
            .num (num_reg[p]),
            .den (den_reg[p % 3]),
            .quo (quo[p])
        );
    end

    logic  vc;
    side_t side_c;

    rbsi_delay #(
        .W     ($bits(side_t)),
        .DEPTH (DIV_LAT)
    ) u_side_delay (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vb_reg),
        .in_data   (side_b_reg),
        .out_valid (vc),
        .out_data  (side_c)
    );

    // Stage C: per-axis entry and exit.
    logic  vc_reg;
    rng_t  rng_c_reg [0:2];
    side_t side_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else
        begin
            vc_reg <= vc;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            rng_c_reg[a].bnd <= !side_c.par[a];
            rng_c_reg[a].lo  <= (quo[a] < quo[a+3]) ? quo[a] : quo[a+3];
            rng_c_reg[a].hi  <= (quo[a] < quo[a+3]) ? quo[a+3] : quo[a];
        end
        side_c_reg <= side_c;
    end

    // Stages D and E: fold the three slabs.
    logic  vd_reg;
    rng_t  rng_d_reg;
    rng_t  rng_z_reg;
    side_t side_d_reg;
    logic  ve_reg;
    rng_t  rng_e_reg;
    side_t side_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rng_d_reg  <= fold(rng_c_reg[0], rng_c_reg[1]);
        rng_z_reg  <= rng_c_reg[2];
        side_d_reg <= side_c_reg;
        rng_e_reg  <= fold(rng_d_reg, rng_z_reg);
        side_e_reg <= side_d_reg;
    end

    // Stage F: hit decision and choice of t.
    logic                 vf_reg;
    logic                 miss_f_reg;
    logic                 unb_f_reg;
    logic signed [QW-1:0] tsel_f_reg;
    side_t                side_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
        end
        else
        begin
            vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        miss_f_reg <= side_e_reg.par_miss || (rng_e_reg.bnd
                      && (rng_e_reg.lo > rng_e_reg.hi || rng_e_reg.hi[QW-1]));
        unb_f_reg  <= !rng_e_reg.bnd;
        tsel_f_reg <= rng_e_reg.lo[QW-1] ? rng_e_reg.hi : rng_e_reg.lo;
        side_f_reg <= side_e_reg;
    end

    // Stage G: saturate t.
    logic   vg_reg;
    logic   miss_g_reg;
    coord_t t_g_reg;
    side_t  side_g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vg_reg <= 1'b0;
        end
        else
        begin
            vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        miss_g_reg <= miss_f_reg;
        t_g_reg    <= unb_f_reg ? COORD_MAX : sat_q(tsel_f_reg);
        side_g_reg <= side_f_reg;
    end

    // Stage H: direction times t.
    logic                 vh_reg;
    logic                 miss_h_reg;
    coord_t               t_h_reg;
    logic signed [PW-1:0] prod_h_reg [0:2];
    coord_t               org_h_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vh_reg <= 1'b0;
        end
        else
        begin
            vh_reg <= vg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        miss_h_reg    <= miss_g_reg;
        t_h_reg       <= t_g_reg;
        prod_h_reg[0] <= side_g_reg.dir_x * t_g_reg;
        prod_h_reg[1] <= side_g_reg.dir_y * t_g_reg;
        prod_h_reg[2] <= side_g_reg.dir_z * t_g_reg;
        org_h_reg[0]  <= side_g_reg.org_x;
        org_h_reg[1]  <= side_g_reg.org_y;
        org_h_reg[2]  <= side_g_reg.org_z;
    end

    // Stage I: hit point and output register.
    coord_t             pt [0:2];
    logic signed [PW:0] sum [0:2];
    logic               done_reg;
    res_t               result_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sum[a] = $signed({{(PW-COORD_W+1){org_h_reg[a][COORD_W-1]}}, org_h_reg[a]})
                   + $signed({prod_h_reg[a][PW-1], (prod_h_reg[a] >>> FRAC_BITS)});
            pt[a]  = sat_p(sum[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vh_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (miss_h_reg)
        begin
            result_reg <= '0;
        end
        else
        begin
            result_reg.hit   <= 1'b1;
            result_reg.hit_t <= t_h_reg;
            result_reg.hit_x <= pt[0];
            result_reg.hit_y <= pt[1];
            result_reg.hit_z <= pt[2];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `RBSI_ASSERT_IMPL(a_miss_zero, done && !result.hit,
        result.hit_t == '0 && result.hit_x == '0 && result.hit_y == '0 && result.hit_z == '0)
    `RBSI_ASSERT_IMPL(a_hit_t_nonneg, done && result.hit, !result.hit_t[COORD_W-1])
    `RBSI_ASSERT_NEXT(a_unbounded_max, vf_reg && !miss_f_reg && unb_f_reg,
        ##2 (done && result.hit && result.hit_t == COORD_MAX))

endmodule
`default_nettype wire
